// ===== rtl/spring_chain_physics_step_macros.svh =====
// Assertion macros for the spring chain block.
`ifndef SPRING_CHAIN_PHYSICS_STEP_MACROS_SVH
`define SPRING_CHAIN_PHYSICS_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define SCP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scp assertion failed");
`define SCP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scp assertion failed");
`else
`define SCP_ASSERT_IMP(label, ante, cons)
`define SCP_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/scp_pkg.sv =====
package scp_pkg;

	localparam int NODE_W = 4;

	localparam logic [3:0] CFG_ORIGIN_X    = 4'd0;
	localparam logic [3:0] CFG_ORIGIN_Y    = 4'd1;
	localparam logic [3:0] CFG_ZONE_WIDTH  = 4'd2;
	localparam logic [3:0] CFG_HEAD_HEIGHT = 4'd3;
	localparam logic [3:0] CFG_REST_LENGTH = 4'd4;
	localparam logic [3:0] CFG_INV_STEP    = 4'd5;
	localparam logic [3:0] CFG_DAMPING     = 4'd6;
	localparam logic [3:0] CFG_GRAVITY     = 4'd7;

	localparam logic signed [31:0] RST_HEAD_HEIGHT = 32'sd3276800;
	localparam logic [30:0] RST_ZONE_WIDTH  = 31'd26214400;
	localparam logic [30:0] RST_REST_LENGTH = 31'd1048576;
	localparam logic [16:0] RST_INV_STEP    = 17'd6554;
	localparam logic [16:0] RST_DAMPING     = 17'd65470;
	localparam logic signed [31:0] RST_GRAVITY = 32'sd1311;

	localparam int POS_X_BASE = 200;
	localparam int POS_X_STEP = 3;
	localparam int POS_Y_BASE = 50;
	localparam int POS_Y_STEP = 8;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [65:0] W_MAX = 66'sh0_7FFF_FFFF;
	localparam logic signed [65:0] W_MIN = -66'sh0_8000_0000;

	typedef enum logic [5:0] {
		OP_IDLE, OP_CAPTURE, OP_PIN_HEAD, OP_PIN_TAIL, OP_LOAD, OP_DIFF,
		OP_SQ1, OP_SQ2, OP_SQ3, OP_SQRT_GO, OP_MAG, OP_DIVX_GO, OP_NX,
		OP_DIVY_GO, OP_NY, OP_DOT1, OP_DOT2, OP_DOT3, OP_DOT4, OP_TERM,
		OP_IMP, OP_HX, OP_HY, OP_HYW, OP_VUPD, OP_WRB, OP_DAMPX, OP_DAMPY,
		OP_DAMPW, OP_INTEG, OP_WRA, OP_EMIT
	} dp_op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_PIN_HEAD, ST_PIN_TAIL, ST_LOAD, ST_DIFF, ST_SQ1, ST_SQ2,
		ST_SQ3, ST_SQRT_GO, ST_SQRT_WAIT, ST_MAG, ST_DIVX_GO, ST_DIVX_WAIT,
		ST_NX, ST_DIVY_GO, ST_DIVY_WAIT, ST_NY, ST_DOT1, ST_DOT2, ST_DOT3,
		ST_DOT4, ST_TERM, ST_IMP, ST_HX, ST_HY, ST_HYW, ST_VUPD, ST_WRB,
		ST_DAMPX, ST_DAMPY, ST_DAMPW, ST_INTEG, ST_WRA, ST_EMIT
	} scp_state_t;

	typedef struct packed {
		dp_op_t            op;
		logic [NODE_W-1:0] node;
		logic              last;
	} scp_cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic div_busy;
		logic out_free;
	} scp_sts_t;

	function automatic logic signed [31:0] sat_w(input logic signed [65:0] v);
		if (v > W_MAX) return S32_MAX;
		if (v < W_MIN) return S32_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat33(input logic [32:0] s);
		if (s[32] != s[31]) return s[32] ? S32_MIN : S32_MAX;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] add32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33({a[31], a} + {b[31], b});
	endfunction

	function automatic logic signed [31:0] sub32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33({a[31], a} - {b[31], b});
	endfunction

endpackage

// ===== rtl/scp_sqrt.sv =====
module scp_sqrt import scp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);

	logic [63:0] rem_q, root_q, bit_q, trial;
	logic [4:0]  cnt_q;
	logic        busy_q;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= '0;
			bit_q  <= 64'd1 << 62;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = root_q[31:0];

endmodule

// ===== rtl/scp_div.sv =====
module scp_div import scp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [30:0] divisor,
	output logic        busy,
	output logic [47:0] quot
);

	logic [47:0] dvd_q;
	logic [30:0] rem_q, dsr_q;
	logic [31:0] trial;
	logic [5:0]  cnt_q;
	logic        busy_q;

	assign trial = {rem_q, dvd_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd47;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= 31'(trial - {1'b0, dsr_q});
				dvd_q <= {dvd_q[46:0], 1'b1};
			end else begin
				rem_q <= trial[30:0];
				dvd_q <= {dvd_q[46:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = dvd_q;

endmodule

// ===== rtl/scp_dp.sv =====
module scp_dp import scp_pkg::*; #(
	parameter int NUM_NODES = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scp_cmd_t           cmd,
	output scp_sts_t           sts,
	input  logic signed [31:0] pointer_x,
	input  logic signed [31:0] pointer_y,
	input  logic               drag_active,
	input  logic               cfg_valid,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         node_index,
	output logic signed [31:0] node_pos_x,
	output logic signed [31:0] node_pos_y,
	output logic               last_node
);

	localparam int NW = $clog2(NUM_NODES);
	localparam logic [NW-1:0] TAIL = NW'(NUM_NODES - 1);

	logic signed [31:0] origin_x_q, origin_y_q, head_height_q, gravity_q;
	logic [30:0] zone_width_q, rest_length_q;
	logic [16:0] inv_step_q, damping_q;

	logic signed [31:0] pos_x_q [NUM_NODES];
	logic signed [31:0] pos_y_q [NUM_NODES];
	logic signed [31:0] vel_x_q [NUM_NODES];
	logic signed [31:0] vel_y_q [NUM_NODES];

	logic signed [31:0] ptr_x_q, ptr_y_q;
	logic               drag_q;
	logic signed [31:0] pa_x_q, pa_y_q, pb_x_q, pb_y_q;
	logic signed [31:0] va_x_q, va_y_q, vb_x_q, vb_y_q;
	logic signed [31:0] dx_q, dy_q, rvx_q, rvy_q;
	logic signed [31:0] nx_q, ny_q, stretch_q, dot_q, term_q, imp_q, hx_q, hy_q;
	logic [30:0]        mag_q;
	logic signed [65:0] prod_q, acc_q;
	logic signed [32:0] mul_a, mul_b;

	logic               out_valid_q, last_q;
	logic [2:0]         index_q;
	logic signed [31:0] out_x_q, out_y_q;

	logic [NW-1:0] a_idx, b_idx;
	logic [31:0]   abs_d;
	logic          neg_d;
	logic [47:0]   quot;
	logic [31:0]   root;
	logic          sqrt_busy, div_busy, out_free;
	logic signed [31:0] q_sat;

	assign a_idx = cmd.node[NW-1:0];
	assign b_idx = NW'(a_idx - 1'b1);
	assign out_free = !out_valid_q || !out_stall;

	assign sts.sqrt_busy = sqrt_busy;
	assign sts.div_busy  = div_busy;
	assign sts.out_free  = out_free;

	always_comb begin
		neg_d = (cmd.op == OP_DIVY_GO) ? dy_q[31] : dx_q[31];
		abs_d = (cmd.op == OP_DIVY_GO) ? dy_q : dx_q;
		if (neg_d) abs_d = ~abs_d + 32'd1;
	end

	always_comb begin
		if ((cmd.op == OP_NY) ? dy_q[31] : dx_q[31]) begin
			if (quot > 48'h0000_8000_0000) q_sat = S32_MIN;
			else q_sat = 32'(~quot[31:0] + 32'd1);
		end else begin
			if (quot > 48'h0000_7FFF_FFFF) q_sat = S32_MAX;
			else q_sat = quot[31:0];
		end
	end

	always_comb begin
		case (cmd.op)
			OP_SQ1: begin
				mul_a = {dx_q[31], dx_q};
				mul_b = {dx_q[31], dx_q};
			end
			OP_SQ2: begin
				mul_a = {dy_q[31], dy_q};
				mul_b = {dy_q[31], dy_q};
			end
			OP_DOT1: begin
				mul_a = {rvx_q[31], rvx_q};
				mul_b = {nx_q[31], nx_q};
			end
			OP_DOT2: begin
				mul_a = {rvy_q[31], rvy_q};
				mul_b = {ny_q[31], ny_q};
			end
			OP_DOT4: begin
				mul_a = {stretch_q[31], stretch_q};
				mul_b = {16'd0, inv_step_q};
			end
			OP_HX: begin
				mul_a = {imp_q[31], imp_q};
				mul_b = {nx_q[31], nx_q};
			end
			OP_HY: begin
				mul_a = {imp_q[31], imp_q};
				mul_b = {ny_q[31], ny_q};
			end
			OP_DAMPX: begin
				mul_a = {va_x_q[31], va_x_q};
				mul_b = {16'd0, damping_q};
			end
			OP_DAMPY: begin
				mul_a = {va_y_q[31], va_y_q};
				mul_b = {16'd0, damping_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	scp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT_GO),
		.radicand (acc_q[63:0]),
		.busy     (sqrt_busy),
		.root     (root)
	);

	scp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIVX_GO || cmd.op == OP_DIVY_GO),
		.dividend ({abs_d, 16'd0}),
		.divisor  (mag_q),
		.busy     (div_busy),
		.quot     (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			zone_width_q  <= RST_ZONE_WIDTH;
			head_height_q <= RST_HEAD_HEIGHT;
			rest_length_q <= RST_REST_LENGTH;
			inv_step_q    <= RST_INV_STEP;
			damping_q     <= RST_DAMPING;
			gravity_q     <= RST_GRAVITY;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < NUM_NODES; i++) begin
				pos_x_q[i] <= 32'((POS_X_BASE + POS_X_STEP * i) * 65536);
				pos_y_q[i] <= 32'((POS_Y_BASE + POS_Y_STEP * i) * 65536);
				vel_x_q[i] <= '0;
				vel_y_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ORIGIN_X:    origin_x_q    <= cfg_data;
					CFG_ORIGIN_Y:    origin_y_q    <= cfg_data;
					CFG_ZONE_WIDTH:  zone_width_q  <= cfg_data[30:0];
					CFG_HEAD_HEIGHT: head_height_q <= cfg_data;
					CFG_REST_LENGTH: rest_length_q <= cfg_data[30:0];
					CFG_INV_STEP:    inv_step_q    <= cfg_data[16:0];
					CFG_DAMPING:     damping_q     <= cfg_data[16:0];
					CFG_GRAVITY:     gravity_q     <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_PIN_HEAD: begin
					pos_x_q[0] <= 32'(zone_width_q >> 1);
					pos_y_q[0] <= head_height_q;
					vel_x_q[0] <= '0;
					vel_y_q[0] <= '0;
				end
				OP_PIN_TAIL: begin
					if (drag_q) begin
						pos_x_q[TAIL] <= sub32(ptr_x_q, origin_x_q);
						pos_y_q[TAIL] <= sub32(ptr_y_q, origin_y_q);
						vel_x_q[TAIL] <= '0;
						vel_y_q[TAIL] <= '0;
					end
				end
				OP_WRB: begin
					vel_x_q[b_idx] <= vb_x_q;
					vel_y_q[b_idx] <= vb_y_q;
				end
				OP_WRA: begin
					pos_x_q[a_idx] <= pa_x_q;
					pos_y_q[a_idx] <= pa_y_q;
					vel_x_q[a_idx] <= va_x_q;
					vel_y_q[a_idx] <= va_y_q;
				end
				default: ;
			endcase
			if (cmd.op == OP_EMIT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_CAPTURE: begin
				ptr_x_q <= pointer_x;
				ptr_y_q <= pointer_y;
				drag_q  <= drag_active;
			end
			OP_LOAD: begin
				pa_x_q <= pos_x_q[a_idx];
				pa_y_q <= pos_y_q[a_idx];
				pb_x_q <= pos_x_q[b_idx];
				pb_y_q <= pos_y_q[b_idx];
				va_x_q <= vel_x_q[a_idx];
				va_y_q <= vel_y_q[a_idx];
				vb_x_q <= vel_x_q[b_idx];
				vb_y_q <= vel_y_q[b_idx];
			end
			OP_DIFF: begin
				dx_q  <= sub32(pa_x_q, pb_x_q);
				dy_q  <= sub32(pa_y_q, pb_y_q);
				rvx_q <= sub32(va_x_q, vb_x_q);
				rvy_q <= sub32(va_y_q, vb_y_q);
			end
			OP_SQ2, OP_DOT2: acc_q <= prod_q;
			OP_SQ3, OP_DOT3: acc_q <= acc_q + prod_q;
			OP_MAG: begin
				if (root[31]) mag_q <= '1;
				else if (root == 32'd0) mag_q <= 31'd1;
				else mag_q <= root[30:0];
			end
			OP_NX: begin
				nx_q      <= q_sat;
				stretch_q <= sub32({1'b0, mag_q}, {1'b0, rest_length_q});
			end
			OP_NY:   ny_q   <= q_sat;
			OP_DOT4: dot_q  <= sat_w(acc_q >>> 16);
			OP_TERM: term_q <= sat_w(prod_q >>> 16);
			OP_IMP:  imp_q  <= add32(dot_q, term_q) >>> 2;
			OP_HY:   hx_q   <= sat_w(prod_q >>> 17);
			OP_HYW:  hy_q   <= sat_w(prod_q >>> 17);
			OP_VUPD: begin
				va_x_q <= sub32(va_x_q, hx_q);
				va_y_q <= sub32(va_y_q, hy_q);
				vb_x_q <= add32(vb_x_q, hx_q);
				vb_y_q <= add32(vb_y_q, hy_q);
			end
			OP_DAMPY: va_x_q <= sat_w(prod_q >>> 16);
			OP_DAMPW: va_y_q <= add32(sat_w(prod_q >>> 16), gravity_q);
			OP_INTEG: begin
				pa_x_q <= add32(pa_x_q, va_x_q);
				pa_y_q <= add32(pa_y_q, va_y_q);
			end
			OP_EMIT: begin
				if (out_free) begin
					index_q <= 3'(a_idx);
					out_x_q <= pos_x_q[a_idx];
					out_y_q <= pos_y_q[a_idx];
					last_q  <= cmd.last;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign node_index = index_q;
	assign node_pos_x = out_x_q;
	assign node_pos_y = out_y_q;
	assign last_node  = last_q;

endmodule

// ===== rtl/scp_ctrl.sv =====
`include "spring_chain_physics_step_macros.svh"
module scp_ctrl import scp_pkg::*; #(
	parameter int NUM_NODES  = 6,
	parameter int ITERATIONS = 10
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  scp_sts_t sts,
	output scp_cmd_t cmd
);

	localparam int NW = $clog2(NUM_NODES);
	localparam int IW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
	localparam logic [NW-1:0] LAST_NODE = NW'(NUM_NODES - 1);
	localparam logic [IW-1:0] LAST_ITER = IW'(ITERATIONS - 1);

	scp_state_t    state_q, state_d;
	logic [NW-1:0] node_q, node_d;
	logic [IW-1:0] iter_q, iter_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			node_q  <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			node_q  <= node_d;
			iter_q  <= iter_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		node_d   = node_q;
		iter_d   = iter_q;
		cmd.op   = OP_IDLE;
		cmd.node = NODE_W'(node_q);
		cmd.last = (node_q == LAST_NODE);
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_PIN_HEAD;
				end
			end
			ST_PIN_HEAD: begin
				cmd.op  = OP_PIN_HEAD;
				state_d = ST_PIN_TAIL;
			end
			ST_PIN_TAIL: begin
				cmd.op  = OP_PIN_TAIL;
				node_d  = NW'(1);
				iter_d  = '0;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.op  = OP_LOAD;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = ST_SQ1;
			end
			ST_SQ1: begin
				cmd.op  = OP_SQ1;
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				cmd.op  = OP_SQ2;
				state_d = ST_SQ3;
			end
			ST_SQ3: begin
				cmd.op  = OP_SQ3;
				state_d = ST_SQRT_GO;
			end
			ST_SQRT_GO: begin
				cmd.op  = OP_SQRT_GO;
				state_d = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (!sts.sqrt_busy) state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.op  = OP_MAG;
				state_d = ST_DIVX_GO;
			end
			ST_DIVX_GO: begin
				cmd.op  = OP_DIVX_GO;
				state_d = ST_DIVX_WAIT;
			end
			ST_DIVX_WAIT: begin
				if (!sts.div_busy) state_d = ST_NX;
			end
			ST_NX: begin
				cmd.op  = OP_NX;
				state_d = ST_DIVY_GO;
			end
			ST_DIVY_GO: begin
				cmd.op  = OP_DIVY_GO;
				state_d = ST_DIVY_WAIT;
			end
			ST_DIVY_WAIT: begin
				if (!sts.div_busy) state_d = ST_NY;
			end
			ST_NY: begin
				cmd.op  = OP_NY;
				state_d = ST_DOT1;
			end
			ST_DOT1: begin
				cmd.op  = OP_DOT1;
				state_d = ST_DOT2;
			end
			ST_DOT2: begin
				cmd.op  = OP_DOT2;
				state_d = ST_DOT3;
			end
			ST_DOT3: begin
				cmd.op  = OP_DOT3;
				state_d = ST_DOT4;
			end
			ST_DOT4: begin
				cmd.op  = OP_DOT4;
				state_d = ST_TERM;
			end
			ST_TERM: begin
				cmd.op  = OP_TERM;
				state_d = ST_IMP;
			end
			ST_IMP: begin
				cmd.op  = OP_IMP;
				state_d = ST_HX;
			end
			ST_HX: begin
				cmd.op  = OP_HX;
				state_d = ST_HY;
			end
			ST_HY: begin
				cmd.op  = OP_HY;
				state_d = ST_HYW;
			end
			ST_HYW: begin
				cmd.op  = OP_HYW;
				state_d = ST_VUPD;
			end
			ST_VUPD: begin
				cmd.op  = OP_VUPD;
				state_d = ST_WRB;
			end
			ST_WRB: begin
				cmd.op  = OP_WRB;
				state_d = ST_DAMPX;
			end
			ST_DAMPX: begin
				cmd.op  = OP_DAMPX;
				state_d = ST_DAMPY;
			end
			ST_DAMPY: begin
				cmd.op  = OP_DAMPY;
				state_d = ST_DAMPW;
			end
			ST_DAMPW: begin
				cmd.op  = OP_DAMPW;
				state_d = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.op  = OP_INTEG;
				state_d = ST_WRA;
			end
			ST_WRA: begin
				cmd.op = OP_WRA;
				if (node_q == LAST_NODE) begin
					if (iter_q == LAST_ITER) begin
						node_d  = '0;
						iter_d  = '0;
						state_d = ST_EMIT;
					end else begin
						node_d  = NW'(1);
						iter_d  = IW'(iter_q + 1'b1);
						state_d = ST_LOAD;
					end
				end else begin
					node_d  = NW'(node_q + 1'b1);
					state_d = ST_LOAD;
				end
			end
			ST_EMIT: begin
				cmd.op = OP_EMIT;
				if (sts.out_free) begin
					if (node_q == LAST_NODE) begin
						node_d  = '0;
						state_d = ST_IDLE;
					end else begin
						node_d = NW'(node_q + 1'b1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SCP_ASSERT_NXT(a_accept_pins, in_valid && !in_stall, state_q == ST_PIN_HEAD)
	`SCP_ASSERT_NXT(a_emit_done, state_q == ST_EMIT && sts.out_free && node_q == LAST_NODE, state_q == ST_IDLE)
	`SCP_ASSERT_IMP(a_units_excl, 1'b1, !(sts.sqrt_busy && sts.div_busy))

endmodule

// ===== rtl/spring_chain_physics_step.sv =====
// Mass-spring chain, one physics tick per input beat.
// Input channel: pointer_x, pointer_y, drag_active; a beat is taken when
// in_valid is high and in_stall low. in_stall is high for the whole tick.
// Output channel: one beat per node, head first, node_index counting up
// and last_node set on the tail; out_stall holds the current beat and
// freezes the walk over the nodes until it is taken.
// Config channel: cfg_index and cfg_data, taken when cfg_valid is high
// (cfg_ready is always high); indexes above 7 are dropped. Write only
// while no tick is in flight.
// Each tick runs ITERATIONS passes over the springs, then sends NUM_NODES
// output beats at one per cycle when not stalled; no new input beat is
// taken until the last output beat has been issued. Each spring update
// runs a 32-step square root and two 48-step divides on one shared root
// unit and one shared divider, each with a start state and a wait state
// to see it finish, plus 24 further steps, some through one 33x33
// multiplier.
// Reset loads the node positions, velocities and config registers to their
// defaults; the block comes out of reset idle and ready to accept a beat.
module spring_chain_physics_step import scp_pkg::*; #(
	parameter int NUM_NODES  = 6,
	parameter int ITERATIONS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pointer_x,
	input  logic signed [31:0] pointer_y,
	input  logic               drag_active,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         node_index,
	output logic signed [31:0] node_pos_x,
	output logic signed [31:0] node_pos_y,
	output logic               last_node,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	scp_cmd_t cmd;
	scp_sts_t sts;

	assign cfg_ready = 1'b1;

	scp_ctrl #(
		.NUM_NODES  (NUM_NODES),
		.ITERATIONS (ITERATIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	scp_dp #(
		.NUM_NODES (NUM_NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pointer_x   (pointer_x),
		.pointer_y   (pointer_y),
		.drag_active (drag_active),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.node_index  (node_index),
		.node_pos_x  (node_pos_x),
		.node_pos_y  (node_pos_y),
		.last_node   (last_node)
	);

endmodule
